// ----- sv/siu_pkg.sv -----
package siu_pkg;

  localparam int unsigned SECTOR_SHIFT = 9;
  localparam int unsigned OFF_W        = SECTOR_SHIFT;
  localparam int unsigned IDX_W        = 5;

  localparam logic [31:0] SPARSE_MAGIC  = 32'hED26_FF3A;
  localparam logic [15:0] SPARSE_MAJOR  = 16'd1;
  localparam logic [15:0] FILE_HDR_LEN  = 16'd28;
  localparam logic [15:0] CHUNK_HDR_LEN = 16'd12;
  localparam logic [15:0] KIND_RAW       = 16'hCAC1;
  localparam logic [15:0] KIND_DONT_CARE = 16'hCAC3;

  // file header byte positions
  localparam logic [IDX_W-1:0] FH_MAGIC_END   = 5'd3;
  localparam logic [IDX_W-1:0] FH_MAJOR_END   = 5'd5;
  localparam logic [IDX_W-1:0] FH_HDRSZ_END   = 5'd9;
  localparam logic [IDX_W-1:0] FH_CHDRSZ_END  = 5'd11;
  localparam logic [IDX_W-1:0] FH_BLKSZ_END   = 5'd15;
  localparam logic [IDX_W-1:0] FH_CHUNKS_END  = 5'd23;
  localparam logic [IDX_W-1:0] FH_LAST        = 5'd27;
  // chunk header byte positions
  localparam logic [IDX_W-1:0] CH_KIND_END    = 5'd1;
  localparam logic [IDX_W-1:0] CH_BLOCKS_END  = 5'd7;
  localparam logic [IDX_W-1:0] CH_LAST        = 5'd11;

  typedef enum logic [3:0] {
    PH_FILE    = 4'b0001,
    PH_CHUNK   = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_IDLE    = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MAGIC    = 3'd1,
    ERR_FORMAT   = 3'd2,
    ERR_RAW_SIZE = 3'd3,
    ERR_DC_SIZE  = 3'd4,
    ERR_KIND     = 3'd5
  } err_e;

  typedef struct packed {
    logic       image_start;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [31:0] sector;
    logic [8:0]  byte_in_sector;
    logic        done_res;
    err_e        error_code;
  } res_t;

endpackage

// ----- sv/sparse_image_unpacker_top.sv -----
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   data_byte_i, image_start_i
// out       output     out_valid_o / out_stall_i payload_valid_o, payload_byte_o, sector_o,
//                                                byte_in_sector_o, done_res_o, error_code_o
// cfg       input      cfg_we_i                  cfg_data_i (start sector)
//
// One byte per cycle sustained unless a stalled output blocks a byte that gives a result; a result
// passes the input register, then parser logic into the output register.
// The 32x32 chunk length multiply sits in the parser stage, once per chunk header.
// Reset (rst_ni low, async) empties both registers and puts the parser at file header byte 0.
// A stalled output holds its transaction; bytes that give no result keep flowing past it.
module sparse_image_unpacker_top import siu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        image_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] sector_o,
  output logic [8:0]  byte_in_sector_o,
  output logic        done_res_o,
  output logic [2:0]  error_code_o
);

  item_t in_item, s1_item;
  logic  s1_valid, adv, out_free, res_load;
  res_t  res, res_q;

  assign in_item.image_start = image_start_i;
  assign in_item.data_byte   = data_byte_i;

  siu_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  siu_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .valid_i     (s1_valid),
    .item_i      (s1_item),
    .out_free_i  (out_free),
    .adv_o       (adv),
    .res_valid_o (res_load),
    .res_o       (res)
  );

  siu_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign payload_valid_o  = res_q.payload_valid;
  assign payload_byte_o   = res_q.payload_byte;
  assign sector_o         = res_q.sector;
  assign byte_in_sector_o = res_q.byte_in_sector;
  assign done_res_o       = res_q.done_res;
  assign error_code_o     = res_q.error_code;

endmodule

// ----- sv/siu_in_reg.sv -----
module siu_in_reg import siu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  adv_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;
  logic  accept;

  assign in_stall_o = valid_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !adv_i |=> valid_q && $stable(item_q))
    else $error("pending byte lost");

endmodule

// ----- sv/siu_parser.sv -----
module siu_parser import siu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        valid_i,
  input  item_t       item_i,
  input  logic        out_free_i,
  output logic        adv_o,
  output logic        res_valid_o,
  output res_t        res_o
);

  logic [31:0]      start_sector_q;
  phase_e           phase_q, phase_d;
  logic [IDX_W-1:0] hdr_idx_q, hdr_idx_d;
  logic [31:0]      field_q, field_d;
  logic [31:0]      block_size_q, block_size_d;
  logic [31:0]      chunks_left_q, chunks_left_d;
  logic [15:0]      chunk_kind_q, chunk_kind_d;
  logic [31:0]      chunk_len_q, chunk_len_d;
  logic [31:0]      pay_left_q, pay_left_d;
  logic [31:0]      pay_wr_q, pay_wr_d;
  logic [31:0]      cur_sector_q, cur_sector_d;
  logic [OFF_W-1:0] sec_off_q, sec_off_d;

  phase_e           ph;
  logic [IDX_W-1:0] idx, idx_inc;
  logic [31:0]      fb, fb_new, mul_lo, chunks_dec, left_dec;
  logic [7:0]       b;
  err_e             err;
  logic             res_vld;
  res_t             res;

  always_comb begin
    b   = item_i.data_byte;
    ph  = phase_q;
    idx = hdr_idx_q;
    fb  = field_q;
    if (item_i.image_start) begin
      ph  = PH_FILE;
      idx = '0;
      fb  = '0;
    end
    unique case (idx[1:0])
      2'd0: fb_new = {24'd0, b};
      2'd1: fb_new = fb | {16'd0, b, 8'd0};
      2'd2: fb_new = fb | {8'd0, b, 16'd0};
      2'd3: fb_new = fb | {b, 24'd0};
      default: fb_new = fb;
    endcase
    idx_inc    = idx + 5'd1;
    mul_lo     = fb_new * block_size_q;
    chunks_dec = chunks_left_q - 32'd1;
    left_dec   = pay_left_q - 32'd1;

    phase_d       = ph;
    hdr_idx_d     = idx;
    field_d       = fb;
    block_size_d  = block_size_q;
    chunks_left_d = chunks_left_q;
    chunk_kind_d  = chunk_kind_q;
    chunk_len_d   = chunk_len_q;
    pay_left_d    = pay_left_q;
    pay_wr_d      = pay_wr_q;
    cur_sector_d  = cur_sector_q;
    sec_off_d     = sec_off_q;
    err           = ERR_NONE;
    res_vld       = 1'b0;
    res           = '0;

    unique case (ph)
      PH_FILE: begin
        field_d   = fb_new;
        hdr_idx_d = idx_inc;
        priority if (idx == FH_MAGIC_END && fb_new != SPARSE_MAGIC) begin
          err = ERR_MAGIC;
        end else if (idx == FH_MAJOR_END && fb_new[15:0] != SPARSE_MAJOR) begin
          err = ERR_FORMAT;
        end else if (idx == FH_HDRSZ_END && fb_new[15:0] != FILE_HDR_LEN) begin
          err = ERR_FORMAT;
        end else if (idx == FH_CHDRSZ_END && fb_new[31:16] != CHUNK_HDR_LEN) begin
          err = ERR_FORMAT;
        end else if (idx == FH_BLKSZ_END) begin
          block_size_d = fb_new;
        end else if (idx == FH_CHUNKS_END) begin
          chunks_left_d = fb_new;
        end else if (idx == FH_LAST) begin
          cur_sector_d = start_sector_q;
          sec_off_d    = '0;
          hdr_idx_d    = '0;
          if (chunks_left_q == 32'd0) begin
            phase_d      = PH_IDLE;
            res_vld      = 1'b1;
            res.done_res = 1'b1;
          end else begin
            phase_d = PH_CHUNK;
          end
        end else begin
        end
      end
      PH_CHUNK: begin
        field_d   = fb_new;
        hdr_idx_d = idx_inc;
        if (idx == CH_KIND_END) begin
          chunk_kind_d = fb_new[15:0];
        end
        if (idx == CH_BLOCKS_END) begin
          chunk_len_d = mul_lo;
        end
        if (idx == CH_LAST) begin
          if (chunk_kind_q == KIND_RAW) begin
            if (fb_new != chunk_len_q + 32'(CHUNK_HDR_LEN)) begin
              err = ERR_RAW_SIZE;
            end else if (chunk_len_q == 32'd0) begin
              chunks_left_d = chunks_dec;
              hdr_idx_d     = '0;
              phase_d       = (chunks_dec == 32'd0) ? PH_IDLE : PH_CHUNK;
              res_vld       = (chunks_dec == 32'd0);
              res.done_res  = (chunks_dec == 32'd0);
            end else begin
              pay_left_d = chunk_len_q;
              pay_wr_d   = {chunk_len_q[31:SECTOR_SHIFT], {SECTOR_SHIFT{1'b0}}};
              sec_off_d  = '0;
              phase_d    = PH_PAYLOAD;
            end
          end else if (chunk_kind_q == KIND_DONT_CARE) begin
            if (fb_new != 32'(CHUNK_HDR_LEN)) begin
              err = ERR_DC_SIZE;
            end else begin
              cur_sector_d  = cur_sector_q + (chunk_len_q >> SECTOR_SHIFT);
              chunks_left_d = chunks_dec;
              hdr_idx_d     = '0;
              phase_d       = (chunks_dec == 32'd0) ? PH_IDLE : PH_CHUNK;
              res_vld       = (chunks_dec == 32'd0);
              res.done_res  = (chunks_dec == 32'd0);
            end
          end else begin
            err = ERR_KIND;
          end
        end
      end
      PH_PAYLOAD: begin
        if (pay_wr_q != 32'd0) begin
          res_vld            = 1'b1;
          res.payload_valid  = 1'b1;
          res.payload_byte   = b;
          res.sector         = cur_sector_q;
          res.byte_in_sector = 9'(sec_off_q);
          pay_wr_d           = pay_wr_q - 32'd1;
          sec_off_d          = sec_off_q + OFF_W'(1);
          if (sec_off_q == {OFF_W{1'b1}}) begin
            cur_sector_d = cur_sector_q + 32'd1;
          end
        end
        pay_left_d = left_dec;
        if (left_dec == 32'd0) begin
          chunks_left_d = chunks_dec;
          hdr_idx_d     = '0;
          phase_d       = (chunks_dec == 32'd0) ? PH_IDLE : PH_CHUNK;
          if (chunks_dec == 32'd0) begin
            res_vld      = 1'b1;
            res.done_res = 1'b1;
          end
        end
      end
      PH_IDLE: begin
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (err != ERR_NONE) begin
      phase_d        = PH_IDLE;
      res_vld        = 1'b1;
      res            = '0;
      res.error_code = err;
    end
  end

  assign adv_o       = valid_i && (!res_vld || out_free_i);
  assign res_valid_o = adv_o && res_vld;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_sector_q <= '0;
    end else if (cfg_we_i) begin
      start_sector_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_FILE;
      hdr_idx_q     <= '0;
      field_q       <= '0;
      block_size_q  <= '0;
      chunks_left_q <= '0;
      chunk_kind_q  <= '0;
      chunk_len_q   <= '0;
      pay_left_q    <= '0;
      pay_wr_q      <= '0;
      cur_sector_q  <= '0;
      sec_off_q     <= '0;
    end else if (adv_o) begin
      phase_q       <= phase_d;
      hdr_idx_q     <= hdr_idx_d;
      field_q       <= field_d;
      block_size_q  <= block_size_d;
      chunks_left_q <= chunks_left_d;
      chunk_kind_q  <= chunk_kind_d;
      chunk_len_q   <= chunk_len_d;
      pay_left_q    <= pay_left_d;
      pay_wr_q      <= pay_wr_d;
      cur_sector_q  <= cur_sector_d;
      sec_off_q     <= sec_off_d;
    end
  end

  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res.error_code != ERR_NONE |=> phase_q == PH_IDLE)
    else $error("parser not parked after error");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res.error_code != ERR_NONE |-> !res.payload_valid && !res.done_res)
    else $error("error result carries data or done");

  a_wr_le_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> pay_wr_q <= pay_left_q && pay_left_q != 32'd0)
    else $error("payload counters out of order");

endmodule

// ----- sv/siu_out_reg.sv -----
module siu_out_reg import siu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic free_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
